### rtl/gle_pkg.sv
// Shared constants and controller/datapath interface types for the GIF LZW encoder.
package gle_pkg;

  localparam int unsigned HashEntriesDef = 8192;
  localparam int unsigned CodeMax        = 4096;
  localparam int unsigned MinWidthReset  = 8;
  localparam int unsigned MinWidthLo     = 2;
  localparam int unsigned MinWidthHi     = 8;

  localparam logic [1:0] PH_INITIAL = 2'd0;
  localparam logic [1:0] PH_FIRST   = 2'd1;
  localparam logic [1:0] PH_HEAD    = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  typedef enum logic [1:0] {
    CODE_CLEAR,
    CODE_END,
    CODE_PREFIX
  } code_sel_e;

  typedef struct packed {
    logic      latch_item;
    logic      clr_run;
    logic      put;
    code_sel_e put_sel;
    logic      drain;
    logic      pad;
    logic      flush;
    logic      flush_done;
    logic      probe_load;
    logic      probe_step;
    logic      rd_en;
    logic      insert;
    logic      prefix_tail;
    logic      prefix_hit;
  } cmd_t;

  typedef struct packed {
    logic has;
    logic last;
    logic cnt_ge8;
    logic cnt_nz;
    logic hold_v;
    logic out_free;
    logic clr_last;
    logic empty;
    logic hit;
    logic nfc_full;
  } status_t;

endpackage

### rtl/gle_ctrl.sv
// Sequencing state machine for the GIF LZW encoder.
module gle_ctrl import gle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_START   = 4'd2;
  localparam logic [3:0] S_BYTE    = 4'd3;
  localparam logic [3:0] S_PROBE   = 4'd4;
  localparam logic [3:0] S_CHECK   = 4'd5;
  localparam logic [3:0] S_MISS    = 4'd6;
  localparam logic [3:0] S_RESTART = 4'd7;
  localparam logic [3:0] S_LAST    = 4'd8;
  localparam logic [3:0] S_END     = 4'd9;
  localparam logic [3:0] S_PAD     = 4'd10;
  localparam logic [3:0] S_FLUSH   = 4'd11;
  localparam logic [3:0] S_DRAIN   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic [1:0] phase_q, phase_d;
  logic       can_emit;

  assign can_emit   = !st_i.hold_v || st_i.out_free;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.put_sel = CODE_CLEAR;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_run = 1'b1;
        if (st_i.clr_last) state_d = ret_q;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          if (phase_q != PH_DONE) state_d = S_START;
        end
      end
      S_START: begin
        if (phase_q == PH_INITIAL) begin
          cmd_o.put     = 1'b1;
          cmd_o.put_sel = CODE_CLEAR;
          phase_d       = PH_FIRST;
          ret_d         = S_BYTE;
          state_d       = S_DRAIN;
        end else begin
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        if (!st_i.has) begin
          state_d = S_LAST;
        end else if (phase_q == PH_FIRST) begin
          cmd_o.prefix_tail = 1'b1;
          phase_d           = PH_HEAD;
          state_d           = S_LAST;
        end else begin
          cmd_o.probe_load = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (st_i.empty) begin
          cmd_o.put     = 1'b1;
          cmd_o.put_sel = CODE_PREFIX;
          ret_d         = S_MISS;
          state_d       = S_DRAIN;
        end else if (st_i.hit) begin
          cmd_o.prefix_hit = 1'b1;
          state_d          = S_LAST;
        end else begin
          cmd_o.probe_step = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_MISS: begin
        if (!st_i.nfc_full) begin
          cmd_o.insert      = 1'b1;
          cmd_o.prefix_tail = 1'b1;
          state_d           = S_LAST;
        end else begin
          cmd_o.put     = 1'b1;
          cmd_o.put_sel = CODE_CLEAR;
          ret_d         = S_RESTART;
          state_d       = S_DRAIN;
        end
      end
      S_RESTART: begin
        cmd_o.prefix_tail = 1'b1;
        ret_d             = S_LAST;
        state_d           = S_CLR;
      end
      S_LAST: begin
        if (!st_i.last) begin
          state_d = S_FLUSH;
        end else if (phase_q == PH_HEAD) begin
          cmd_o.put     = 1'b1;
          cmd_o.put_sel = CODE_PREFIX;
          ret_d         = S_END;
          state_d       = S_DRAIN;
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = CODE_END;
        ret_d         = S_PAD;
        state_d       = S_DRAIN;
      end
      S_PAD: begin
        if (!st_i.cnt_nz) begin
          phase_d = PH_DONE;
          state_d = S_FLUSH;
        end else if (can_emit) begin
          cmd_o.pad = 1'b1;
          phase_d   = PH_DONE;
          state_d   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st_i.hold_v) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.flush      = 1'b1;
          cmd_o.flush_done = (phase_q == PH_DONE);
          state_d          = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (!st_i.cnt_ge8) begin
          state_d = ret_q;
        end else if (can_emit) begin
          cmd_o.drain = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      state_d = S_CLR;
      ret_d   = S_IDLE;
      phase_d = PH_INITIAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
      phase_q <= PH_INITIAL;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
    end
  end

endmodule

### rtl/gle_datapath.sv
// Dictionary memory, code registers, bit packer and output register of the GIF LZW encoder.
module gle_datapath import gle_pkg::*; #(
  parameter int unsigned HashEntries = HashEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_has_i,
  input  logic       in_last_i,
  input  cmd_t       cmd_i,
  output status_t    st_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_done_o
);

  localparam int unsigned IdxW = $clog2(HashEntries);

  logic [31:0]     mem [HashEntries];
  logic [31:0]     rdata_q;
  logic [IdxW-1:0] clr_addr_q;
  logic [IdxW-1:0] probe_q;

  logic [3:0]  min_q;
  logic [7:0]  tail_q;
  logic        has_q, last_q;
  logic [11:0] prefix_q;
  logic [12:0] nfc_q, limit_q;
  logic [3:0]  width_q;
  logic [18:0] acc_q;
  logic [4:0]  cnt_q;
  logic        hold_v_q;
  logic [7:0]  hold_q;
  logic        out_v_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_done_q;

  logic [3:0]      eff;
  logic [12:0]     clr_code;
  logic [12:0]     code_raw;
  logic [11:0]     code_mask;
  logic [13:0]     hx;
  logic [18:0]     hm;
  logic [IdxW-1:0] hash_idx;
  logic [IdxW-1:0] step_idx;
  logic            out_free;
  logic            emit;
  logic [7:0]      emit_byte;

  always_comb begin
    eff = min_q;
    if (min_q < 4'(MinWidthLo)) eff = 4'(MinWidthLo);
    if (min_q > 4'(MinWidthHi)) eff = 4'(MinWidthHi);
  end

  assign clr_code = 13'(1) << eff;

  always_comb begin
    case (cmd_i.put_sel)
      CODE_CLEAR:  code_raw = clr_code;
      CODE_END:    code_raw = clr_code + 13'd1;
      CODE_PREFIX: code_raw = {1'b0, prefix_q};
      default:     code_raw = clr_code;
    endcase
  end

  assign code_mask = 12'((13'(1) << width_q) - 13'd1);

  assign hx       = {2'b00, prefix_q} ^ {tail_q, 6'b0};
  assign hm       = {hx, 5'b0} - {5'b0, hx};
  assign hash_idx = hm[IdxW-1:0];
  assign step_idx = (IdxW)'({tail_q, 2'b01});

  assign out_free  = !out_v_q || out_ready_i;
  assign emit      = cmd_i.drain || cmd_i.pad;
  assign emit_byte = acc_q[7:0];

  assign st_o.has      = has_q;
  assign st_o.last     = last_q;
  assign st_o.cnt_ge8  = (cnt_q >= 5'd8);
  assign st_o.cnt_nz   = (cnt_q != 5'd0);
  assign st_o.hold_v   = hold_v_q;
  assign st_o.out_free = out_free;
  assign st_o.clr_last = (clr_addr_q == {IdxW{1'b1}});
  assign st_o.empty    = (rdata_q == 32'd0);
  assign st_o.hit      = (rdata_q[19:0] == {prefix_q, tail_q});
  assign st_o.nfc_full = (nfc_q >= 13'(CodeMax));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_run) begin
      mem[clr_addr_q] <= 32'd0;
    end else if (cmd_i.insert) begin
      mem[probe_q] <= {nfc_q[11:0], prefix_q, tail_q};
    end
    if (cmd_i.rd_en) rdata_q <= mem[probe_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      tail_q <= in_byte_i;
      has_q  <= in_has_i;
      last_q <= in_last_i;
    end
    if (cmd_i.probe_load) begin
      probe_q <= hash_idx;
    end else if (cmd_i.probe_step) begin
      probe_q <= probe_q - step_idx;
    end
    if (emit) hold_q <= emit_byte;
    if (emit && hold_v_q) begin
      out_byte_q <= hold_q;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_byte_q <= hold_q;
      out_last_q <= 1'b1;
      out_done_q <= cmd_i.flush_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= 4'(MinWidthReset);
      clr_addr_q <= '0;
      prefix_q   <= '0;
      nfc_q      <= 13'((1 << MinWidthReset) + 2);
      limit_q    <= 13'((2 << MinWidthReset) - 1);
      width_q    <= 4'(MinWidthReset + 1);
      acc_q      <= '0;
      cnt_q      <= '0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q      <= cfg_wdata_i;
        clr_addr_q <= '0;
        prefix_q   <= '0;
        acc_q      <= '0;
        cnt_q      <= '0;
        hold_v_q   <= 1'b0;
      end else begin
        if (cmd_i.clr_run) begin
          clr_addr_q <= clr_addr_q + 1'b1;
          nfc_q      <= clr_code + 13'd2;
          limit_q    <= {clr_code[11:0], 1'b0} - 13'd1;
          width_q    <= eff + 4'd1;
        end else if (cmd_i.insert) begin
          nfc_q <= nfc_q + 13'd1;
          if (nfc_q > limit_q) begin
            limit_q <= {limit_q[11:0], 1'b1};
            width_q <= width_q + 4'd1;
          end
        end
        if (cmd_i.prefix_tail) begin
          prefix_q <= {4'd0, tail_q};
        end else if (cmd_i.prefix_hit) begin
          prefix_q <= rdata_q[31:20];
        end
        if (cmd_i.put) begin
          acc_q <= acc_q | (19'(code_raw[11:0] & code_mask) << cnt_q);
          cnt_q <= cnt_q + 5'(width_q);
        end else if (cmd_i.drain) begin
          acc_q <= acc_q >> 8;
          cnt_q <= cnt_q - 5'd8;
        end else if (cmd_i.pad) begin
          acc_q <= '0;
          cnt_q <= '0;
        end
        if (emit) begin
          hold_v_q <= 1'b1;
        end else if (cmd_i.flush) begin
          hold_v_q <= 1'b0;
        end
      end
      if ((emit && hold_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

### rtl/gif_lzw_encoder_unit.sv
// Top level of the GIF LZW encoder: pixel request stream in, packed code byte stream out.
//
//  channel  | dir | tdata          | tuser          | tlast
//  s_axis   | in  | [7:0] data     | [0] has_byte   | is_last
//  m_axis   | out | [7:0] out_byte | [0] stream_done| last_of_run
//  cfg      | in  | cfg_wdata_i[3:0] min_code_width, written on cfg_we_i
//
// A request passes through accept, start, byte, last and flush, plus a probe and a check
// per dictionary probe; each code written passes through drain for each byte it completes,
// a miss through a miss step, end of data through end code and pad. One request is handled at a time.
// After reset, a configuration write and each dictionary-full clear, a clearing
// pass over all HASH_ENTRIES dictionary entries runs with s_axis_tready_o low.
// Output bytes leave through a hold register and an output register; a stalled m_axis holds the
// packer, which then holds the input.
module gif_lzw_encoder_unit import gle_pkg::*; #(
  parameter int unsigned HASH_ENTRIES = HashEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] has_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] stream_done
  output logic       m_axis_tlast_o
);

  cmd_t    cmd;
  status_t st;

  gle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gle_datapath #(
    .HashEntries (HASH_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_has_i    (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_done_o  (m_axis_tuser_o)
  );

endmodule

### tb/sv/tb_gif_lzw_encoder_unit.sv
// Testbench for the GIF LZW encoder: drives pixel requests and checks packed code bytes.
`timescale 1ns / 100ps

module tb_gif_lzw_encoder_unit;
  import gle_pkg::*;

  localparam int unsigned DictDepth = 8192;
  localparam int unsigned WatchLimit = 40000;

  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } code_byte_t;

  class lzw_scoreboard;
    bit [31:0]   dict [DictDepth];
    int unsigned min_w;
    int unsigned prefix;
    int unsigned free_code;
    int unsigned w_limit;
    int unsigned code_w;
    int unsigned bit_buf;
    int unsigned free_bits;
    logic [1:0]  phase;
    code_byte_t  pending_q [$];
    code_byte_t  step_q [$];
    int          errors;

    function int unsigned eff_min();
      int unsigned m;
      m = min_w;
      if (m < MinWidthLo) m = MinWidthLo;
      if (m > MinWidthHi) m = MinWidthHi;
      return m;
    endfunction

    function int unsigned clr_value();
      return 1 << eff_min();
    endfunction

    function void restart_dict();
      free_code = clr_value() + 2;
      w_limit   = 2 * clr_value() - 1;
      code_w    = eff_min() + 1;
      foreach (dict[i]) dict[i] = '0;
    endfunction

    function void configure(int unsigned v);
      min_w = v & 'hF;
      restart_dict();
      prefix    = 0;
      bit_buf   = 0;
      free_bits = 8;
      phase     = PH_INITIAL;
    endfunction

    function void emit_byte(int unsigned b);
      code_byte_t e;
      e.out_byte    = b[7:0];
      e.last_of_run = 1'b0;
      e.stream_done = 1'b0;
      step_q.push_back(e);
    endfunction

    function void push_code(int unsigned code);
      int unsigned left;
      int unsigned n;
      left = code_w;
      while (left > 0) begin
        n = (free_bits < left) ? free_bits : left;
        bit_buf = (bit_buf | ((code & ((1 << n) - 1)) << (8 - free_bits))) & 'hFF;
        code = code >> n;
        free_bits -= n;
        left -= n;
        if (free_bits == 0) begin
          emit_byte(bit_buf);
          bit_buf   = 0;
          free_bits = 8;
        end
      end
    endfunction

    function void compress_byte(int unsigned tail);
      int unsigned key;
      int unsigned probe;
      int unsigned stride;
      int unsigned tries;
      bit [31:0]   e;
      key    = ((prefix & 'hFFF) << 8) | tail;
      probe  = ((prefix ^ (tail << 6)) * 31) & (DictDepth - 1);
      stride = ((tail << 2) | 1) & (DictDepth - 1);
      for (tries = 0; tries < DictDepth; tries++) begin
        e = dict[probe];
        if (e == 0) break;
        if ((e & 'hFFFFF) == key) begin
          prefix = (e >> 20) & 'hFFF;
          return;
        end
        probe = (probe - stride) & (DictDepth - 1);
      end
      push_code(prefix);
      if (free_code < CodeMax) begin
        if (tries < DictDepth) dict[probe] = (free_code << 20) | key;
        if (free_code > w_limit) begin
          w_limit = w_limit * 2 + 1;
          code_w++;
        end
        free_code++;
      end else begin
        push_code(clr_value());
        restart_dict();
      end
      prefix = tail;
    endfunction

    function void note_request(logic [7:0] b, logic has, logic last);
      step_q.delete();
      if (phase == PH_DONE) return;
      if (phase == PH_INITIAL) begin
        restart_dict();
        push_code(clr_value());
        phase = PH_FIRST;
      end
      if (has) begin
        if (phase == PH_FIRST) begin
          prefix = b;
          phase  = PH_HEAD;
        end else begin
          compress_byte(b);
        end
      end
      if (last) begin
        if (phase == PH_HEAD) push_code(prefix);
        push_code(clr_value() + 1);
        if (free_bits < 8) begin
          emit_byte(bit_buf);
          bit_buf   = 0;
          free_bits = 8;
        end
        phase = PH_DONE;
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].last_of_run = 1'b1;
        if (phase == PH_DONE) step_q[step_q.size()-1].stream_done = 1'b1;
      end
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [7:0] b, logic lst, logic done);
      code_byte_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected output byte %0h", b);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte expected %0h actual %0h", e.out_byte, b);
        errors++;
      end
      if (lst !== e.last_of_run) begin
        $error("last_of_run expected %0b actual %0b", e.last_of_run, lst);
        errors++;
      end
      if (done !== e.stream_done) begin
        $error("stream_done expected %0b actual %0b", e.stream_done, done);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic       s_axis_tuser_i = 1'b0;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  lzw_scoreboard sb = new();
  int  burst_left;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;

  gif_lzw_encoder_unit u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: stall pattern chosen at random among four modes, long hold on demand
  initial begin : rx_stall
    int cyc;
    int mode;
    int hold_cnt;
    bit hold_seen;
    cyc = 0;
    mode = 0;
    hold_cnt = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_cnt  = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i = 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i = 1'b1;
          1: m_axis_tready_i = ($urandom_range(0, 9) < 7);
          2: m_axis_tready_i = ($urandom_range(0, 9) < 3);
          default: m_axis_tready_i = ((cyc % 5) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [7:0] b, input logic has, input logic last);
    if (burst_left <= 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tuser_i  = has;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(b, has, last);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain_out();
    s_axis_tvalid_i = 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_min_width(input logic [3:0] v);
    drain_out();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.configure(v);
  endtask

  task automatic run_stream(input int n, input int alphabet, input bit stray);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = (alphabet > 0) ? 8'($urandom_range(0, alphabet - 1)) : 8'($urandom);
      send_req(b, ($urandom_range(0, 15) != 0), (i == n - 1));
    end
    if (stray) send_req(8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    burst_left = 0;
    sb.configure(MinWidthReset);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: clear-only step, extremes, repeats for hits, idle step, end
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hA5, 1'b1, 1'b1);
    send_req(8'h5A, 1'b1, 1'b1);
    drain_out();
    write_min_width(4'd2);
    send_req(8'h03, 1'b0, 1'b1);
    write_min_width(4'd0);
    send_req(8'h01, 1'b1, 1'b0);
    send_req(8'h02, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);
    write_min_width(4'd15);
    send_req(8'h80, 1'b1, 1'b1);
    write_min_width(4'd8);
    run_stream(4, 2, 1'b1);

    // random streams over several widths
    for (int s = 0; s < 10; s++) begin
      write_min_width(4'($urandom_range(0, 15)));
      if (s == 4) hold_req = 1'b1;
      run_stream($urandom_range(10, 30), ($urandom_range(0, 2) == 0) ? 0 : 4, s % 3 == 0);
    end

    drain_out();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
